// File: rtl/size_class_slot_allocator_unit_assert.svh
// Assertion macros used by the slot allocator RTL top level.
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge out of reset.
`define SCSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SCSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`else

`define SCSA_ASSERT_SAME(lbl, ante, cons)
`define SCSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/scsa_pkg.sv
// Package with field widths, request, size class and status codes and default pool sizes.
`timescale 1ns / 1ps

package scsa_pkg;

    // Fixed field widths of the request and response.
    localparam int CMD_W    = 1;
    localparam int CLASS_W  = 2;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;

    // Default size of each class range.
    localparam int DEF_BASIC_SLOTS    = 16;
    localparam int DEF_DATAGRAM_SLOTS = 8;
    localparam int DEF_SNIP_SLOTS     = 4;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    // Size classes.
    localparam logic [CLASS_W-1:0] CLS_BASIC    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_DATAGRAM = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_SNIP     = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_INVALID  = 2'd3;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CLASS    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREE_RELEASE = 2'd3;

endpackage

// File: rtl/size_class_slot_allocator_unit.sv
// Slot pool allocator with three size classes: top level with request and response registers.
// A request accepted into the request register has its response registered in the response
// register, from which it is taken.
// Throughput: one request per cycle while the response side is not stalled; the lowest-free-slot
// priority encoder and bitmap update sit in one stage between the request and response registers.
// Reset (rst_n, asynchronous, active low) frees every slot and clears the in-use and peak counts.
`timescale 1ns / 1ps

`include "size_class_slot_allocator_unit_assert.svh"

module size_class_slot_allocator_unit #(
    parameter int BASIC_SLOTS    = scsa_pkg::DEF_BASIC_SLOTS,
    parameter int DATAGRAM_SLOTS = scsa_pkg::DEF_DATAGRAM_SLOTS,
    parameter int SNIP_SLOTS     = scsa_pkg::DEF_SNIP_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [scsa_pkg::CMD_W-1:0]        cmd,
    input  logic [scsa_pkg::CLASS_W-1:0]      size_class,
    input  logic [scsa_pkg::SLOT_W-1:0]       slot_index,

    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [scsa_pkg::STATUS_W-1:0]     status,
    output logic [scsa_pkg::SLOT_W-1:0]       granted_slot,
    output logic [scsa_pkg::SLOT_W-1:0]       in_use,
    output logic [scsa_pkg::SLOT_W-1:0]       peak_in_use
);

    import scsa_pkg::*;

    // The pool is the three class ranges laid end to end.
    localparam int TOTAL = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS;
    localparam int IDX_W = $clog2(TOTAL);
    localparam int CNT_W = $clog2(TOTAL + 1);

    // Request register. The valid bit is control state; the payload is loaded
    // only when a request is accepted and needs no reset.
    logic                req_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [CLASS_W-1:0]  class_reg;
    logic [SLOT_W-1:0]   slot_reg;

    // Allocator state: one bit per slot (1 = allocated), the in-use count and its peak.
    logic [TOTAL-1:0]    map_reg;
    logic [TOTAL-1:0]    map_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    peak_reg;
    logic [CNT_W-1:0]    peak_next;

    // Response register.
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [SLOT_W-1:0]   grant_reg;
    logic [SLOT_W-1:0]   grant_next;
    logic [SLOT_W-1:0]   in_use_reg;
    logic [SLOT_W-1:0]   peak_out_reg;

    logic                rsp_free;
    logic                do_step;
    logic                found;
    logic                alloc_grant;
    logic [IDX_W-1:0]    found_slot;
    logic [IDX_W-1:0]    rel_idx;
    logic                rel_in_pool;

    // The response register can take a new response when it is empty or its
    // current response is being taken at this edge. A request moves from the
    // request register into the response register, and updates the state, at
    // exactly those edges. The request side stalls only when both registers
    // hold requests and the response side is stalled, so a request can enter
    // every cycle while responses flow.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign do_step   = req_valid_reg && rsp_free;
    assign req_stall = req_valid_reg && !rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            cmd_reg   <= cmd;
            class_reg <= size_class;
            slot_reg  <= slot_index;
        end
    end

    // Lowest free slot in the requested class's range, from the current bitmap.
    scsa_find #(
        .BASIC_SLOTS    (BASIC_SLOTS),
        .DATAGRAM_SLOTS (DATAGRAM_SLOTS),
        .SNIP_SLOTS     (SNIP_SLOTS)
    ) u_find (
        .alloc_map  (map_reg),
        .size_class (class_reg),
        .found      (found),
        .slot       (found_slot)
    );

    // An allocate in a valid class that finds a free slot in its range.
    assign alloc_grant = (cmd_reg == CMD_ALLOC) && (class_reg != CLS_INVALID) && found;

    // A release may name any 5-bit slot; those at or past the end of the pool
    // are never allocated and report a release of a free slot.
    assign rel_idx     = IDX_W'(slot_reg);
    assign rel_in_pool = 32'(slot_reg) < 32'(TOTAL);

    // Next state and response for the request in the request register.
    always_comb
    begin
        status_next = ST_OK;
        grant_next  = '0;
        map_next    = map_reg;
        count_next  = count_reg;
        peak_next   = peak_reg;
        if (cmd_reg == CMD_RELEASE)
        begin
            if (rel_in_pool && map_reg[rel_idx])
            begin
                map_next[rel_idx] = 1'b0;
                count_next        = count_reg - 1'b1;
            end
            else
            begin
                // Releasing a free slot changes nothing.
                status_next = ST_FREE_RELEASE;
            end
        end
        else
        begin
            case (class_reg)
                CLS_INVALID:
                begin
                    status_next = ST_BAD_CLASS;
                end
                default:
                begin
                    if (alloc_grant)
                    begin
                        map_next[found_slot] = 1'b1;
                        count_next           = count_reg + 1'b1;
                        grant_next           = SLOT_W'(found_slot);
                        if (count_next > peak_reg)
                        begin
                            peak_next = count_next;
                        end
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_step)
            begin
                map_reg   <= map_next;
                count_reg <= count_next;
                peak_reg  <= peak_next;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    // Response payload; the counts reported are those after this request.
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            status_reg   <= status_next;
            grant_reg    <= grant_next;
            in_use_reg   <= SLOT_W'(count_next);
            peak_out_reg <= SLOT_W'(peak_next);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign granted_slot = grant_reg;
    assign in_use       = in_use_reg;
    assign peak_in_use  = peak_out_reg;

    // The in-use count always matches the number of allocated slots in the bitmap.
    `SCSA_ASSERT_SAME(a_count_matches_map, 1'b1, count_reg == CNT_W'($countones(map_reg)))
    // The peak never falls below the current count.
    `SCSA_ASSERT_SAME(a_peak_covers_count, 1'b1, peak_reg >= count_reg)
    // A granted allocate raises the count by exactly one.
    `SCSA_ASSERT_NEXT(a_grant_counts_up, do_step && alloc_grant, count_reg == $past(count_reg) + 1'b1)

endmodule

// File: rtl/scsa_find.sv
// Lowest-free-slot search within the range of one size class.
`timescale 1ns / 1ps

module scsa_find #(
    parameter int BASIC_SLOTS    = scsa_pkg::DEF_BASIC_SLOTS,
    parameter int DATAGRAM_SLOTS = scsa_pkg::DEF_DATAGRAM_SLOTS,
    parameter int SNIP_SLOTS     = scsa_pkg::DEF_SNIP_SLOTS,
    localparam int TOTAL         = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS,
    localparam int IDX_W         = $clog2(TOTAL)
) (
    input  logic [TOTAL-1:0]                 alloc_map,
    input  logic [scsa_pkg::CLASS_W-1:0]     size_class,
    output logic                             found,
    output logic [IDX_W-1:0]                 slot
);

    import scsa_pkg::*;

    localparam int BND_W = IDX_W + 1;

    logic [BND_W-1:0] lo;
    logic [BND_W-1:0] hi;

    // Range bounds of the class; an invalid class gets an empty range.
    always_comb
    begin
        case (size_class)
            CLS_BASIC:
            begin
                lo = '0;
                hi = BND_W'(BASIC_SLOTS);
            end
            CLS_DATAGRAM:
            begin
                lo = BND_W'(BASIC_SLOTS);
                hi = BND_W'(BASIC_SLOTS + DATAGRAM_SLOTS);
            end
            CLS_SNIP:
            begin
                lo = BND_W'(BASIC_SLOTS + DATAGRAM_SLOTS);
                hi = BND_W'(TOTAL);
            end
            default:
            begin
                lo = '0;
                hi = '0;
            end
        endcase
    end

    // Priority encoder: scanning from the top down, the last hit is the lowest free slot.
    always_comb
    begin
        found = 1'b0;
        slot  = '0;
        for (int i = TOTAL - 1; i >= 0; i--)
        begin
            if (!alloc_map[i] && (BND_W'(i) >= lo) && (BND_W'(i) < hi))
            begin
                found = 1'b1;
                slot  = IDX_W'(i);
            end
        end
    end

endmodule

// File: tb/size_class_slot_allocator_checker.sv
// Checker for the slot allocator: predicts each response and compares it with the block.
`timescale 1ns / 1ps

module size_class_slot_allocator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [scsa_pkg::CMD_W-1:0]    cmd,
    input  logic [scsa_pkg::CLASS_W-1:0]  size_class,
    input  logic [scsa_pkg::SLOT_W-1:0]   slot_index,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [scsa_pkg::STATUS_W-1:0] status,
    input  logic [scsa_pkg::SLOT_W-1:0]   granted_slot,
    input  logic [scsa_pkg::SLOT_W-1:0]   in_use,
    input  logic [scsa_pkg::SLOT_W-1:0]   peak_in_use,
    output int                            mismatch_count,
    output int                            replies_owed
);

    import scsa_pkg::*;

    localparam int DATAGRAM_BASE = DEF_BASIC_SLOTS;
    localparam int SNIP_BASE     = DEF_BASIC_SLOTS + DEF_DATAGRAM_SLOTS;
    localparam int POOL_SLOTS    = SNIP_BASE + DEF_SNIP_SLOTS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   used;
        logic [SLOT_W-1:0]   peak;
    } slot_reply_t;

    logic [POOL_SLOTS-1:0] pool_map;
    int                    used_slots;
    int                    peak_slots;
    slot_reply_t           replies_due[$];
    slot_reply_t           due;

    // Applies one request to the shadow pool and returns the response it must produce.
    function automatic slot_reply_t grant_or_free(input logic [CMD_W-1:0] op,
                                                  input logic [CLASS_W-1:0] cls,
                                                  input logic [SLOT_W-1:0] idx);
        slot_reply_t r;
        int          lo;
        int          hi;
        bit          found;
        r = '0;
        r.status = ST_OK;
        if (op == CMD_RELEASE)
        begin
            if (idx >= POOL_SLOTS || !pool_map[idx])
            begin
                r.status = ST_FREE_RELEASE;
            end
            else
            begin
                pool_map[idx] = 1'b0;
                used_slots--;
            end
        end
        else if (cls == CLS_INVALID)
        begin
            r.status = ST_BAD_CLASS;
        end
        else
        begin
            case (cls)
                CLS_BASIC:
                begin
                    lo = 0;
                    hi = DATAGRAM_BASE;
                end
                CLS_DATAGRAM:
                begin
                    lo = DATAGRAM_BASE;
                    hi = SNIP_BASE;
                end
                default:
                begin
                    lo = SNIP_BASE;
                    hi = POOL_SLOTS;
                end
            endcase
            found = 1'b0;
            for (int s = lo; s < hi; s++)
            begin
                if (!found && !pool_map[s])
                begin
                    found = 1'b1;
                    pool_map[s] = 1'b1;
                    r.slot = SLOT_W'(s);
                    used_slots++;
                    if (peak_slots < used_slots)
                        peak_slots = used_slots;
                end
            end
            if (!found)
                r.status = ST_FULL;
        end
        r.used = SLOT_W'(used_slots);
        r.peak = SLOT_W'(peak_slots);
        return r;
    endfunction

    // Responses are checked before the request of the same edge is predicted; a request
    // cannot be answered at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_map = '0;
            used_slots = 0;
            peak_slots = 0;
            replies_due.delete();
            mismatch_count = 0;
            replies_owed = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d slot %0d",
                           status, granted_slot);
                    mismatch_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, status);
                        mismatch_count++;
                    end
                    if (granted_slot !== due.slot)
                    begin
                        $error("granted_slot: expected %0d, got %0d", due.slot, granted_slot);
                        mismatch_count++;
                    end
                    if (in_use !== due.used)
                    begin
                        $error("in_use: expected %0d, got %0d", due.used, in_use);
                        mismatch_count++;
                    end
                    if (peak_in_use !== due.peak)
                    begin
                        $error("peak_in_use: expected %0d, got %0d", due.peak, peak_in_use);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                replies_due.push_back(grant_or_free(cmd, size_class, slot_index));
            replies_owed = replies_due.size();
        end
    end

endmodule

// File: tb/tb_size_class_slot_allocator_unit.sv
// Top of the slot allocator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_size_class_slot_allocator_unit;

    import scsa_pkg::*;

    // The block answers through its request and response registers, so a handful of cycles
    // after the last response is plenty to catch anything spurious.
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int CYCLE_LIMIT     = 200000;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [CMD_W-1:0]    cmd;
    logic [CLASS_W-1:0]  size_class;
    logic [SLOT_W-1:0]   slot_index;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [SLOT_W-1:0]   in_use;
    logic [SLOT_W-1:0]   peak_in_use;

    int mismatch_count;
    int replies_owed;

    // Idle odds in percent for each side, changed from phase to phase.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // The stimulus asks for a long receiver hold-off by raising the first counter; the
    // receiver process serves it and raises the second. Each counter has one writer.
    int hold_off_asked  = 0;
    int hold_off_served = 0;

    int cycle_count = 0;

    size_class_slot_allocator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .size_class   (size_class),
        .slot_index   (slot_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .granted_slot (granted_slot),
        .in_use       (in_use),
        .peak_in_use  (peak_in_use)
    );

    size_class_slot_allocator_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .size_class     (size_class),
        .slot_index     (slot_index),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .granted_slot   (granted_slot),
        .in_use         (in_use),
        .peak_in_use    (peak_in_use),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Response side. Stalls at random at the current odds, and on request holds off for a
    // long stretch so that the block fills up and pushes back on its request port.
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_asked != hold_off_served)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_served++;
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one request, after a random idle gap, and returns at the edge that accepts it.
    // Valid stays high on return so that a following request can go out back to back.
    task automatic issue_request(input logic [CMD_W-1:0] op,
                                 input logic [CLASS_W-1:0] cls,
                                 input logic [SLOT_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        cmd        <= op;
        size_class <= cls;
        slot_index <= idx;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // A run of random requests. With a high allocate share the class ranges fill up and
    // report full; with a low one most slots get freed again and double releases show up.
    // Releases mostly name slots inside the pool, now and then one beyond it.
    task automatic random_burst(input int count, input int alloc_pct);
        int                 pick;
        logic [CLASS_W-1:0] cls;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < alloc_pct)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    cls = CLS_BASIC;
                else if (pick < 70)
                    cls = CLS_DATAGRAM;
                else if (pick < 90)
                    cls = CLS_SNIP;
                else
                    cls = CLS_INVALID;
                issue_request(CMD_ALLOC, cls, SLOT_W'($urandom_range(31)));
            end
            else if ($urandom_range(9) == 0)
            begin
                issue_request(CMD_RELEASE, CLASS_W'($urandom_range(3)),
                              SLOT_W'($urandom_range(31, 28)));
            end
            else
            begin
                issue_request(CMD_RELEASE, CLASS_W'($urandom_range(3)),
                              SLOT_W'($urandom_range(27)));
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        cmd        <= CMD_ALLOC;
        size_class <= CLS_BASIC;
        slot_index <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling. First grants of each class, then an invalid class.
        issue_request(CMD_ALLOC, CLS_BASIC, 5'd0);
        issue_request(CMD_ALLOC, CLS_DATAGRAM, 5'd31);
        issue_request(CMD_ALLOC, CLS_SNIP, 5'd0);
        issue_request(CMD_ALLOC, CLS_INVALID, 5'd31);
        // Release of a held slot, then the same slot again: a double release.
        issue_request(CMD_RELEASE, CLS_BASIC, 5'd0);
        issue_request(CMD_RELEASE, CLS_INVALID, 5'd0);
        // Releases naming slots past the end of the pool, the largest index among them.
        issue_request(CMD_RELEASE, CLS_SNIP, 5'd31);
        issue_request(CMD_RELEASE, CLS_DATAGRAM, 5'd28);
        // Fill the snip range, then ask once more so that it reports full.
        issue_request(CMD_ALLOC, CLS_SNIP, 5'd7);
        issue_request(CMD_ALLOC, CLS_SNIP, 5'd15);
        issue_request(CMD_ALLOC, CLS_SNIP, 5'd16);
        issue_request(CMD_ALLOC, CLS_SNIP, 5'd27);
        // Free the top slot of the pool and take it back as the only free one in range.
        issue_request(CMD_RELEASE, CLS_SNIP, 5'd27);
        issue_request(CMD_ALLOC, CLS_SNIP, 5'd0);
        // The freed datagram slot is granted again before the next one up.
        issue_request(CMD_RELEASE, CLS_DATAGRAM, 5'd16);
        issue_request(CMD_ALLOC, CLS_DATAGRAM, 5'd31);
        issue_request(CMD_ALLOC, CLS_DATAGRAM, 5'd0);
        // A lower count after releases must leave the peak where it was.
        issue_request(CMD_RELEASE, CLS_BASIC, 5'd24);
        issue_request(CMD_RELEASE, CLS_BASIC, 5'd17);
        issue_request(CMD_ALLOC, CLS_BASIC, 5'd27);
        issue_request(CMD_RELEASE, CLS_INVALID, 5'd15);

        // Random part in four idling phases: none, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 49;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct = 34;
                end
            endcase
            for (int round = 0; round < 4; round++)
            begin
                random_burst(44, 80);
                random_burst(24, 25);
            end

            // After the first phase, back-to-back requests against a long hold-off on the
            // response side, so that the block's buffering fills and it stalls requests.
            if (phase == 0)
            begin
                hold_off_asked++;
                random_burst(40, 60);
            end
        end

        // One more edge lets the checker book the last accepted request before the
        // outstanding count is read.
        req_valid <= 1'b0;
        @(posedge clk);
        wait (replies_owed == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
